>>> hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape block: decoder phases,
// result kinds, character codes and the result group passed to the emitter.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	// Result kind carried on the output tuser
	typedef enum logic [2:0] {
		K_BYTE    = 3'd0,
		K_END     = 3'd1,
		K_NOQUOTE = 3'd2,
		K_UNTERM  = 3'd3,
		K_BADESC  = 3'd4,
		K_TRUNC   = 3'd5
	} kind_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned MAX_RES = 3;
	localparam int unsigned CNT_W = 2;

	// Character codes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_LC_N = 8'h6E;
	localparam logic [7:0] CH_LC_R = 8'h72;
	localparam logic [7:0] CH_LC_T = 8'h74;
	localparam logic [7:0] CH_LC_B = 8'h62;
	localparam logic [7:0] CH_LC_F = 8'h66;
	localparam logic [7:0] CH_LC_U = 8'h75;

	// Up to three results caused by one source byte; kind is shared because
	// only plain bytes come in groups larger than one.
	typedef struct packed {
		logic [CNT_W-1:0]                 cnt;
		kind_t                            kind;
		logic [MAX_RES-1:0][BYTE_W-1:0]   data;
	} grp_t;

endpackage

>>> hw/rtl/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and per-byte decode: whitespace skip, quote detection, escape
// mapping, \u hex accumulation and UTF-8 encoding into a result group.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic [7:0]          item_byte,
	input  logic                item_end,
	input  logic                take,
	output jsu_pkg::grp_t       grp
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [15:0] code_point_q, code_point_d;
	logic        hex_stopped_q, hex_stopped_d;

	logic        is_dig, is_lc, is_uc, is_hex;
	logic [3:0]  digit;
	logic [15:0] cp_new;
	logic        hs_new;
	logic [7:0]  esc_byte;

	// Classify the byte as a hex digit
	always_comb begin
		is_dig = (item_byte >= 8'h30) && (item_byte <= 8'h39);
		is_lc  = (item_byte >= 8'h61) && (item_byte <= 8'h66);
		is_uc  = (item_byte >= 8'h41) && (item_byte <= 8'h46);
		is_hex = is_dig || is_lc || is_uc;
		if (is_dig) begin
			digit = item_byte[3:0];
		end else begin
			digit = 4'(item_byte[3:0] + 4'd9);
		end
	end

	// Accumulate the code point until a non-hex byte stops it
	always_comb begin
		cp_new = code_point_q;
		hs_new = hex_stopped_q;
		if (!hex_stopped_q) begin
			if (is_hex) begin
				cp_new = {code_point_q[11:0], digit};
			end else begin
				hs_new = 1'b1;
			end
		end
	end

	// Map the byte after a backslash
	always_comb begin
		case (item_byte)
			CH_LC_N: esc_byte = CH_LF;
			CH_LC_R: esc_byte = CH_CR;
			CH_LC_T: esc_byte = CH_TAB;
			CH_LC_B: esc_byte = CH_BS;
			CH_LC_F: esc_byte = CH_FF;
			default: esc_byte = item_byte;
		endcase
	end

	// Next state and result group
	always_comb begin
		phase_d       = phase_q;
		hex_count_d   = hex_count_q;
		code_point_d  = code_point_q;
		hex_stopped_d = hex_stopped_q;
		grp           = '0;
		grp.kind      = K_BYTE;
		unique case (phase_q)
			PH_WAIT: begin
				if (item_end) begin
					grp.cnt  = 2'd1;
					grp.kind = K_NOQUOTE;
				end else if (item_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
					phase_d = PH_WAIT;
				end else if (item_byte == CH_QUOTE) begin
					phase_d = PH_STR;
				end else begin
					grp.cnt  = 2'd1;
					grp.kind = K_NOQUOTE;
				end
			end
			PH_STR: begin
				if (item_end) begin
					grp.cnt  = 2'd1;
					grp.kind = K_UNTERM;
					phase_d  = PH_WAIT;
				end else if (item_byte == CH_QUOTE) begin
					grp.cnt  = 2'd1;
					grp.kind = K_END;
					phase_d  = PH_WAIT;
				end else if (item_byte == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					grp.cnt     = 2'd1;
					grp.data[0] = item_byte;
				end
			end
			PH_ESC: begin
				if (item_end) begin
					grp.cnt  = 2'd1;
					grp.kind = K_BADESC;
					phase_d  = PH_WAIT;
				end else if (item_byte == CH_LC_U) begin
					hex_count_d   = '0;
					code_point_d  = '0;
					hex_stopped_d = 1'b0;
					phase_d       = PH_HEX;
				end else begin
					grp.cnt     = 2'd1;
					grp.data[0] = esc_byte;
					phase_d     = PH_STR;
				end
			end
			PH_HEX: begin
				if (item_end) begin
					grp.cnt       = 2'd1;
					grp.kind      = K_TRUNC;
					hex_count_d   = '0;
					code_point_d  = '0;
					hex_stopped_d = 1'b0;
					phase_d       = PH_WAIT;
				end else if (hex_count_q == 2'd3) begin
					// Encode the finished code point as UTF-8
					if (cp_new[15:7] == '0) begin
						grp.cnt     = 2'd1;
						grp.data[0] = cp_new[7:0];
					end else if (cp_new[15:11] == '0) begin
						grp.cnt     = 2'd2;
						grp.data[0] = {3'b110, cp_new[10:6]};
						grp.data[1] = {2'b10, cp_new[5:0]};
					end else begin
						grp.cnt     = 2'd3;
						grp.data[0] = {4'b1110, cp_new[15:12]};
						grp.data[1] = {2'b10, cp_new[11:6]};
						grp.data[2] = {2'b10, cp_new[5:0]};
					end
					hex_count_d   = '0;
					code_point_d  = '0;
					hex_stopped_d = 1'b0;
					phase_d       = PH_STR;
				end else begin
					hex_count_d   = 2'(hex_count_q + 2'd1);
					code_point_d  = cp_new;
					hex_stopped_d = hs_new;
				end
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	// Advance the parser state when the held byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			hex_count_q   <= '0;
			code_point_q  <= '0;
			hex_stopped_q <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_d;
			hex_count_q   <= hex_count_d;
			code_point_q  <= code_point_d;
			hex_stopped_q <= hex_stopped_d;
		end
	end

	// Hex scratch state is clear outside of a \u escape
	a_hex_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEX) |-> (hex_count_q == 2'd0 && code_point_q == 16'd0 && !hex_stopped_q))
		else $error("hex state not cleared outside \\u escape");

	// Multi-byte groups only come from a finished \u escape
	a_multi_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && grp.cnt > 2'd1) |-> (phase_q == PH_HEX && hex_count_q == 2'd3))
		else $error("multi-byte group outside \\u escape");

	// A closing quote inside a string returns to waiting
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && take && !item_end && phase_q == PH_STR && item_byte == CH_QUOTE)
		|=> (phase_q == PH_WAIT))
		else $error("closing quote did not end the string");

endmodule

>>> hw/rtl/jsu_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one result group and hands its results out one
// transfer at a time, taking the next group as the last one leaves.
// ----------------------------------------------------------------------------
module jsu_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  jsu_pkg::grp_t       grp,
	input  logic                load,
	output logic                grp_ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [7:0] out_byte
	output logic [2:0]          m_tuser,   // [2:0] kind
	output logic                m_tlast    // last_of_run
);
	import jsu_pkg::*;

	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               idx_q;
	kind_t                          kind_q;
	logic [MAX_RES-1:0][BYTE_W-1:0] data_q;
	logic                           xfer;

	// Present the current result
	always_comb begin
		m_tvalid  = (cnt_q != '0);
		m_tlast   = (2'(idx_q + 2'd1) == cnt_q);
		m_tdata   = data_q[idx_q];
		m_tuser   = kind_q;
		xfer      = m_tvalid && m_tready;
		grp_ready = !m_tvalid || (xfer && m_tlast);
	end

	// Hold the group payload
	always_ff @(posedge clk) begin
		if (load && grp_ready) begin
			kind_q <= grp.kind;
			data_q <= grp.data;
		end
	end

	// Advance through the group or take the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load && grp_ready) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (xfer) begin
			if (m_tlast) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= 2'(idx_q + 2'd1);
			end
		end
	end

	// Index stays inside the held group
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q < cnt_q))
		else $error("result index beyond group");

	// A group is not dropped after a non-final transfer
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !m_tlast) |=> m_tvalid)
		else $error("group lost mid-way");

	// A loaded non-empty group shows up at the output
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(load && grp_ready && grp.cnt != 2'd0) |=> (m_tvalid && idx_q == 2'd0))
		else $error("loaded group not presented");

endmodule

>>> hw/rtl/json_string_unescape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming JSON string literal decoder: source bytes in, unescaped UTF-8
// bytes and end/error markers out.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle into an input register while the
// held byte can retire, decodes it in a single combinational pass and loads the
// zero to three results it causes into a result register that feeds the master
// stream one transfer per cycle while m_tready is high. Bytes that cause no
// result (whitespace, the opening quote, a backslash, the first three \u
// digits) retire without touching the output. A byte that causes results waits
// in the input register until the result register is free, so the two or three
// bytes of a UTF-8 sequence from a \u escape hold back the next byte that causes
// results. Each result passes through the input register and the result
// register. tlast marks the final result caused by one source byte.
module json_string_unescape (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] byte_value
	input  logic [0:0]  s_tuser,    // [0] input_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] out_byte
	output logic [2:0]  m_tuser,    // [2:0] kind
	output logic        m_tlast     // last_of_run
);
	import jsu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	grp_t       grp;
	logic       grp_ready;
	logic       adv;

	// Retire the held byte when its results fit in the result register
	always_comb begin
		adv      = valid_s1 && ((grp.cnt == '0) || grp_ready);
		s_tready = !valid_s1 || adv;
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tuser[0];
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item_byte  (byte_s1),
		.item_end   (end_s1),
		.take       (adv),
		.grp        (grp)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.load      (adv && (grp.cnt != '0)),
		.grp_ready (grp_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

>>> tb/sv/jsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// Watches both stream ports of the JSON string unescape block, decodes every
// accepted source byte on its own and compares each result transfer, field by
// field, with the oldest decoded result still awaited.
// ----------------------------------------------------------------------------
module jsu_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] byte_value
	input  logic [0:0]  s_tuser,    // [0] input_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,    // [7:0] out_byte
	input  logic [2:0]  m_tuser,    // [2:0] kind
	input  logic        m_tlast,
	output int unsigned fail_count,
	output int unsigned pending
);
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} result_t;

	// Decoded results not yet seen on the master port, oldest first
	result_t     awaited[$];
	int unsigned errors = 0;

	// Decoder state of the prediction
	phase_t      dec_phase = PH_WAIT;
	logic [1:0]  hex_seen = '0;
	logic [15:0] code_acc = '0;
	logic        hex_halted = 1'b0;

	// Results caused by the source byte being decoded
	result_t     step_out[3];
	int unsigned step_n;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Value of a hex digit in [3:0], bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f")
			return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F")
			return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	task automatic add_result(input logic [7:0] d, input kind_t k);
		step_out[step_n] = '{data: d, kind: k, last: 1'b0};
		step_n++;
	endtask

	task automatic clear_hex();
		hex_seen = '0;
		code_acc = '0;
		hex_halted = 1'b0;
	endtask

	// Decode one source transfer and queue the results it causes
	task automatic decode_source_byte(input logic [7:0] c, input logic ended);
		logic [4:0]  hv;
		logic [15:0] cp;
		logic [7:0]  mapped;
		result_t     r;
		step_n = 0;
		case (dec_phase)
			PH_WAIT: begin
				if (ended || !(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
						c == CH_QUOTE))
					add_result(8'h00, K_NOQUOTE);
				else if (c == CH_QUOTE)
					dec_phase = PH_STR;
			end
			PH_STR: begin
				if (ended) begin
					add_result(8'h00, K_UNTERM);
					dec_phase = PH_WAIT;
				end else if (c == CH_QUOTE) begin
					add_result(8'h00, K_END);
					dec_phase = PH_WAIT;
				end else if (c == CH_BSLASH) begin
					dec_phase = PH_ESC;
				end else begin
					add_result(c, K_BYTE);
				end
			end
			PH_ESC: begin
				if (ended) begin
					add_result(8'h00, K_BADESC);
					dec_phase = PH_WAIT;
				end else if (c == CH_LC_U) begin
					clear_hex();
					dec_phase = PH_HEX;
				end else begin
					case (c)
						CH_LC_N: mapped = CH_LF;
						CH_LC_R: mapped = CH_CR;
						CH_LC_T: mapped = CH_TAB;
						CH_LC_B: mapped = CH_BS;
						CH_LC_F: mapped = CH_FF;
						default: mapped = c;
					endcase
					add_result(mapped, K_BYTE);
					dec_phase = PH_STR;
				end
			end
			default: begin
				if (ended) begin
					add_result(8'h00, K_TRUNC);
					clear_hex();
					dec_phase = PH_WAIT;
				end else begin
					// a non-hex byte freezes the code point for the rest of the escape
					if (!hex_halted) begin
						hv = hex_digit(c);
						if (!hv[4])
							hex_halted = 1'b1;
						else
							code_acc = {code_acc[11:0], hv[3:0]};
					end
					if (hex_seen == 2'd3) begin
						cp = code_acc;
						if (cp < 16'h0080) begin
							add_result(cp[7:0], K_BYTE);
						end else if (cp < 16'h0800) begin
							add_result({3'b110, cp[10:6]}, K_BYTE);
							add_result({2'b10, cp[5:0]}, K_BYTE);
						end else begin
							add_result({4'b1110, cp[15:12]}, K_BYTE);
							add_result({2'b10, cp[11:6]}, K_BYTE);
							add_result({2'b10, cp[5:0]}, K_BYTE);
						end
						clear_hex();
						dec_phase = PH_STR;
					end else begin
						hex_seen = hex_seen + 2'd1;
					end
				end
			end
		endcase
		for (int unsigned i = 0; i < step_n; i++) begin
			r = step_out[i];
			r.last = (i == step_n - 1);
			awaited = {awaited, r};
		end
	endtask

	task automatic check_result();
		result_t want;
		if (awaited.size() == 0) begin
			report_mismatch($sformatf("result with none awaited: data=%02h kind=%0d last=%0b",
				m_tdata, m_tuser, m_tlast));
		end else begin
			want = awaited.pop_front();
			if (m_tdata !== want.data)
				report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
			if (m_tuser !== want.kind)
				report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, want.kind));
			if (m_tlast !== want.last)
				report_mismatch($sformatf("last_of_run %0b, expected %0b", m_tlast, want.last));
		end
	endtask

	// Check result transfers, then decode source transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited.delete();
			dec_phase = PH_WAIT;
			clear_hex();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				decode_source_byte(s_tdata, s_tuser[0]);
		end
		fail_count <= errors;
		pending <= awaited.size();
	end

endmodule

>>> tb/sv/tb_json_string_unescape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape
// Drives source bytes into the JSON string unescape block: a directed run over
// the edge cases, then random string literals (mostly well formed, some cut
// short, some with stray bytes) in bursts, against a stalling result sink.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;
	import jsu_pkg::*;

	localparam int unsigned RUN_LIMIT = 200000;
	localparam int unsigned ITEM_TARGET = 250;
	localparam int unsigned SETTLE_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned items = 0;
	int unsigned burst_left = 0;
	logic [7:0]  stall_step = '0;
	logic [7:0]  source_q[$];

	string       ESC_CHARS = "\"\\/nrtbf";

	always #6 clk = ~clk;

	json_string_unescape i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	jsu_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Stall the sink in rotating windows: always ready, mostly ready, ready when
	// the low two step bits are zero, coin flip
	always @(posedge clk) begin
		stall_step <= stall_step + 8'd1;
		case (stall_step[7:6])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= (stall_step[1:0] == 2'd0);
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Send one source transfer, opening a gap first when the burst is used up
	task automatic send_byte(input logic [7:0] b, input logic ended, input bit counted);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= ended;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (counted)
			items++;
	endtask

	task automatic send_end();
		send_byte(8'($urandom), 1'b1, 1'b1);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0, 1'b1);
	endtask

	// Hold off the source until every awaited result has come out
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Append one byte to the string being built
	task automatic add_source(input logic [7:0] b);
		source_q = {source_q, b};
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return "0" + {4'd0, v};
		return (upper ? "A" : "a") + {4'd0, v} - 8'd10;
	endfunction

	// Build one string literal with random content, then send it whole, cut
	// short by an end marker, or behind stray bytes
	task automatic send_random_string();
		int unsigned open_at;
		int unsigned cut;
		int unsigned stop_at;
		int unsigned pick;
		logic [15:0] cp;
		logic [7:0]  b;
		source_q.delete();
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 3))
				0: add_source(CH_SPACE);
				1: add_source(CH_TAB);
				2: add_source(CH_CR);
				default: add_source(CH_LF);
			endcase
		end
		open_at = source_q.size();
		add_source(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 3))
				0: begin
					do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
					add_source(b);
				end
				1: begin
					add_source(CH_BSLASH);
					pick = $urandom_range(0, 9);
					if (pick < 8) begin
						add_source(ESC_CHARS[pick]);
					end else begin
						do b = 8'($urandom); while (b == CH_LC_U);
						add_source(b);
					end
				end
				default: begin
					add_source(CH_BSLASH);
					add_source(CH_LC_U);
					case ($urandom_range(0, 3))
						0: cp = 16'($urandom_range(16'h0000, 16'h007F));
						1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
						default: begin
							case ($urandom_range(0, 5))
								0: cp = 16'h0000;
								1: cp = 16'h007F;
								2: cp = 16'h0080;
								3: cp = 16'h07FF;
								4: cp = 16'h0800;
								default: cp = 16'hFFFF;
							endcase
						end
					endcase
					// sometimes a non-hex byte ends the digits early
					stop_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
					for (int unsigned i = 0; i < 4; i++) begin
						if (i == stop_at)
							add_source($urandom_range(0, 1) ? 8'(8'h67 + $urandom_range(0, 19))
								: 8'(8'h80 + $urandom_range(0, 127)));
						else if (i > stop_at)
							add_source(8'($urandom));
						else
							add_source(hex_char(cp[15 - 4*i -: 4], 1'($urandom_range(0, 1))));
					end
				end
			endcase
		end
		add_source(CH_QUOTE);

		pick = $urandom_range(0, 19);
		cut = source_q.size();
		if (pick < 3) begin
			cut = $urandom_range(open_at + 1, source_q.size() - 1);
		end else if (pick < 6) begin
			// stray bytes or an end marker before the string opens
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 3) == 0)
					send_end();
				else
					send_byte(8'($urandom), 1'b0, 1'b1);
			end
		end
		for (int unsigned i = 0; i < cut; i++)
			send_byte(source_q[i], 1'b0, i >= open_at);
		if (cut < source_q.size())
			send_end();
	endtask

	initial begin
		bit drained_mid;
		drained_mid = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: whitespace, byte extremes, largest code point, no hex digit
		send_byte(CH_SPACE, 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_text("\\uFFFF\\uz12f\"");
		// stray byte and end while waiting
		send_text("x");
		send_end();
		// end inside a string, after a backslash, inside \u digits
		send_text("\"");
		send_end();
		send_text("\"\\");
		send_end();
		send_text("\"\\u0");
		send_end();
		wait_for_drain();

		// Random string literals
		while (items < ITEM_TARGET) begin
			send_random_string();
			if (!drained_mid && items >= ITEM_TARGET / 2) begin
				wait_for_drain();
				drained_mid = 1'b1;
			end
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_emit.sv
hw/rtl/json_string_unescape.sv
tb/sv/jsu_checker.sv
tb/sv/tb_json_string_unescape.sv
